/* sv/dtq_pkg.sv */
// Shared types and codes for the deadline timer queue.
`timescale 1ns / 1ps

package dtq_pkg;

   localparam int DEF_TABLE_DEPTH = 16;
   localparam int DEF_ID_BITS     = 16;
   localparam int MAX_RESULTS     = 16;
   // The command queue depth must be a power of two.
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [1:0] KIND_SCHEDULE = 2'd0;
   localparam logic [1:0] KIND_CANCEL   = 2'd1;
   localparam logic [1:0] KIND_TICK     = 2'd2;
   localparam logic [1:0] KIND_CLEAR    = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   typedef enum logic [2:0] {
      OP_SCHEDULE,
      OP_CANCEL,
      OP_CANCEL_NONE,
      OP_TICK,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] delay;
      logic [15:0] tid;
      logic [15:0] tag;
   } cmd_type;

endpackage

/* sv/dtq_front.sv */
// Command intake: classifies request words and buffers them in a short queue.
`timescale 1ns / 1ps

module dtq_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_kind,
   input  logic [31:0]      req_delay,
   input  logic [15:0]      req_timer_id,
   input  logic [15:0]      req_user_tag,
   output logic             cmd_valid,
   input  logic             cmd_pop,
   output dtq_pkg::cmd_type cmd
);
   import dtq_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   cmd_type               slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   fill_ff, fill_in;
   cmd_type               word;
   logic                  push;
   logic                  pop;

   always_comb begin
      word.delay = req_delay;
      word.tid   = req_timer_id;
      word.tag   = req_user_tag;
      case (req_kind)
         KIND_SCHEDULE: word.op = OP_SCHEDULE;
         KIND_CANCEL:   word.op = (req_timer_id == 16'd0) ? OP_CANCEL_NONE : OP_CANCEL;
         KIND_TICK:     word.op = OP_TICK;
         KIND_CLEAR:    word.op = OP_CLEAR;
         default:       word.op = OP_CLEAR;
      endcase
   end

   assign busy      = (fill_ff == CNT_BITS'(QUEUE_DEPTH));
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign push      = start && !busy;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= word;
      end
   end

endmodule

/* sv/dtq_back.sv */
// Timer table engine: sorted entry cells, time base, id counter and result strobes.
`timescale 1ns / 1ps

module dtq_back #(
   parameter int TABLE_DEPTH = dtq_pkg::DEF_TABLE_DEPTH,
   parameter int ID_BITS     = dtq_pkg::DEF_ID_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cmd_valid,
   output logic                               cmd_pop,
   input  dtq_pkg::cmd_type                   cmd,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_done_kind,
   output logic [15:0]                        rsp_result_id,
   output logic [15:0]                        rsp_result_tag,
   output logic [1:0]                         rsp_status,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]   rsp_pending,
   output logic                               rsp_last
);
   import dtq_pkg::*;

   localparam int PEND_BITS  = $clog2(TABLE_DEPTH + 1);
   localparam int IDW        = (ID_BITS > 16) ? ID_BITS : 16;
   localparam int BURST_BITS = $clog2(MAX_RESULTS);

   typedef enum logic [1:0] {ST_IDLE, ST_INSERT, ST_CANCEL, ST_EXPIRE} state_type;
   typedef enum logic [1:0] {TB_HOLD, TB_INSERT, TB_SHIFT_OUT, TB_CLEAR} action_type;

   state_type              state_ff, state_in;
   logic [63:0]            now_ff, now_in;
   logic [ID_BITS-1:0]     next_id_ff, next_id_in;
   logic [PEND_BITS-1:0]   count_ff, count_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [63:0]            deadline_ff [TABLE_DEPTH];
   logic [63:0]            deadline_in [TABLE_DEPTH];
   logic [ID_BITS-1:0]     eid_ff [TABLE_DEPTH];
   logic [ID_BITS-1:0]     eid_in [TABLE_DEPTH];
   logic [15:0]            etag_ff [TABLE_DEPTH];
   logic [15:0]            etag_in [TABLE_DEPTH];
   logic [63:0]            dl_ff, dl_in;
   logic [15:0]            ntag_ff, ntag_in;
   logic [15:0]            tid_ff, tid_in;
   logic [TABLE_DEPTH-1:0] match_ff, match_in;
   logic [BURST_BITS-1:0]  burst_ff, burst_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_kind_ff, rsp_kind_in;
   logic [15:0]            rsp_id_ff, rsp_id_in;
   logic [15:0]            rsp_tag_ff, rsp_tag_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [PEND_BITS-1:0]   rsp_pending_ff, rsp_pending_in;
   logic                   rsp_last_ff, rsp_last_in;

   action_type             action;
   logic [TABLE_DEPTH-1:0] le;
   logic [TABLE_DEPTH-1:0] match_now;
   logic [TABLE_DEPTH-1:0] gone;
   logic [TABLE_DEPTH-1:0] gone_prefix;
   logic [ID_BITS-1:0]     nid;
   logic                   due0;
   logic                   due1;
   logic                   full;
   logic                   final_expiry;

   always_comb begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         le[k]        = valid_ff[k] && (deadline_ff[k] <= dl_ff);
         match_now[k] = valid_ff[k] && (IDW'(eid_ff[k]) == IDW'(cmd.tid));
      end
   end

   always_comb begin
      logic acc;
      acc = 1'b0;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         acc            = acc | match_ff[k];
         gone_prefix[k] = acc;
      end
   end

   always_comb begin
      nid = next_id_ff + ID_BITS'(1);
      if (nid == '0) begin
         nid = ID_BITS'(1);
      end
   end

   assign due0         = valid_ff[0] && (deadline_ff[0] <= now_ff);
   assign due1         = valid_ff[1] && (deadline_ff[1] <= now_ff);
   assign full         = (count_ff == PEND_BITS'(TABLE_DEPTH));
   assign final_expiry = (burst_ff == BURST_BITS'(MAX_RESULTS - 1)) || !due1;

   always_comb begin
      state_in       = state_ff;
      now_in         = now_ff;
      next_id_in     = next_id_ff;
      count_in       = count_ff;
      dl_in          = dl_ff;
      ntag_in        = ntag_ff;
      tid_in         = tid_ff;
      match_in       = match_ff;
      burst_in       = burst_ff;
      cmd_pop        = 1'b0;
      action         = TB_HOLD;
      gone           = '0;
      rsp_valid_in   = 1'b0;
      rsp_kind_in    = KIND_SCHEDULE;
      rsp_id_in      = '0;
      rsp_tag_in     = '0;
      rsp_status_in  = STATUS_OK;
      rsp_pending_in = count_ff;
      rsp_last_in    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  OP_SCHEDULE: begin
                     if (full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        next_id_in = nid;
                        dl_in      = now_ff + 64'(cmd.delay);
                        ntag_in    = cmd.tag;
                        state_in   = ST_INSERT;
                     end
                  end
                  OP_CANCEL: begin
                     tid_in   = cmd.tid;
                     match_in = match_now;
                     state_in = ST_CANCEL;
                  end
                  OP_CANCEL_NONE: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_CANCEL;
                  end
                  OP_TICK: begin
                     now_in   = now_ff + 64'd1;
                     burst_in = '0;
                     state_in = ST_EXPIRE;
                  end
                  OP_CLEAR: begin
                     action         = TB_CLEAR;
                     count_in       = '0;
                     rsp_valid_in   = 1'b1;
                     rsp_kind_in    = KIND_CLEAR;
                     rsp_pending_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_INSERT: begin
            action         = TB_INSERT;
            count_in       = count_ff + PEND_BITS'(1);
            rsp_valid_in   = 1'b1;
            rsp_id_in      = 16'(next_id_ff);
            rsp_pending_in = count_ff + PEND_BITS'(1);
            state_in       = ST_IDLE;
         end
         ST_CANCEL: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_CANCEL;
            if (match_ff != '0) begin
               action         = TB_SHIFT_OUT;
               gone           = gone_prefix;
               count_in       = count_ff - PEND_BITS'(1);
               rsp_id_in      = tid_ff;
               rsp_pending_in = count_ff - PEND_BITS'(1);
            end else begin
               rsp_status_in = STATUS_NOT_FOUND;
            end
            state_in = ST_IDLE;
         end
         ST_EXPIRE: begin
            if (due0) begin
               action         = TB_SHIFT_OUT;
               gone           = '1;
               count_in       = count_ff - PEND_BITS'(1);
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = KIND_TICK;
               rsp_id_in      = 16'(eid_ff[0]);
               rsp_tag_in     = etag_ff[0];
               rsp_pending_in = count_ff - PEND_BITS'(1);
               rsp_last_in    = final_expiry;
               burst_in       = burst_ff + BURST_BITS'(1);
               if (final_expiry) begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         deadline_in[k] = deadline_ff[k];
         eid_in[k]      = eid_ff[k];
         etag_in[k]     = etag_ff[k];
      end
      case (action)
         TB_INSERT: begin
            if (!le[0]) begin
               deadline_in[0] = dl_ff;
               eid_in[0]      = next_id_ff;
               etag_in[0]     = ntag_ff;
               valid_in[0]    = 1'b1;
            end
            for (int k = 1; k < TABLE_DEPTH; k++) begin
               if (!le[k]) begin
                  if (le[k-1]) begin
                     deadline_in[k] = dl_ff;
                     eid_in[k]      = next_id_ff;
                     etag_in[k]     = ntag_ff;
                     valid_in[k]    = 1'b1;
                  end else begin
                     deadline_in[k] = deadline_ff[k-1];
                     eid_in[k]      = eid_ff[k-1];
                     etag_in[k]     = etag_ff[k-1];
                     valid_in[k]    = valid_ff[k-1];
                  end
               end
            end
         end
         TB_SHIFT_OUT: begin
            for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
               if (gone[k]) begin
                  deadline_in[k] = deadline_ff[k+1];
                  eid_in[k]      = eid_ff[k+1];
                  etag_in[k]     = etag_ff[k+1];
                  valid_in[k]    = valid_ff[k+1];
               end
            end
            if (gone[TABLE_DEPTH-1]) begin
               valid_in[TABLE_DEPTH-1] = 1'b0;
            end
         end
         TB_CLEAR: valid_in = '0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         next_id_ff   <= '0;
         count_ff     <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         next_id_ff   <= next_id_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         deadline_ff[k] <= deadline_in[k];
         eid_ff[k]      <= eid_in[k];
         etag_ff[k]     <= etag_in[k];
      end
      dl_ff          <= dl_in;
      ntag_ff        <= ntag_in;
      tid_ff         <= tid_in;
      match_ff       <= match_in;
      burst_ff       <= burst_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_pending_ff <= rsp_pending_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_done_kind  = rsp_kind_ff;
   assign rsp_result_id  = rsp_id_ff;
   assign rsp_result_tag = rsp_tag_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_pending    = rsp_pending_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

/* sv/deadline_timer_queue_top.sv */
// Top level of the deadline timer queue: command intake, queue and timer table engine.
//
//   Channel   Handshake                    Ports
//   request   accepted when start && !busy req_kind, req_delay, req_timer_id, req_user_tag
//   result    one-cycle strobe rsp_valid   rsp_done_kind, rsp_result_id, rsp_result_tag,
//                                          rsp_status, rsp_pending, rsp_last
//
// The front puts one word per cycle, while not busy, into a two-word queue; busy means full.
// The engine answers a clear, a cancel of id 0 or a refused schedule from its idle state;
// a schedule, a cancel by id or a tick passes through the insert, cancel or expire state,
// and a tick that expires timers stays in expire for each expired timer (at most sixteen).
// Results are registered; each shows in the cycle after the engine makes it, one per cycle.
// Reset clears the table at once through its valid bits; no clearing pass follows.
// Results cannot be stalled, so each strobe is taken in the cycle it is shown.
`timescale 1ns / 1ps

module deadline_timer_queue_top #(
   parameter int TABLE_DEPTH = dtq_pkg::DEF_TABLE_DEPTH,
   parameter int ID_BITS     = dtq_pkg::DEF_ID_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_kind,
   input  logic [31:0]                        req_delay,
   input  logic [15:0]                        req_timer_id,
   input  logic [15:0]                        req_user_tag,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_done_kind,
   output logic [15:0]                        rsp_result_id,
   output logic [15:0]                        rsp_result_tag,
   output logic [1:0]                         rsp_status,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]   rsp_pending,
   output logic                               rsp_last
);
   import dtq_pkg::*;

   localparam int PEND_BITS = $clog2(TABLE_DEPTH + 1);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   dtq_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_kind     (req_kind),
      .req_delay    (req_delay),
      .req_timer_id (req_timer_id),
      .req_user_tag (req_user_tag),
      .cmd_valid    (cmd_valid),
      .cmd_pop      (cmd_pop),
      .cmd          (cmd)
   );

   dtq_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd_pop        (cmd_pop),
      .cmd            (cmd),
      .rsp_valid      (rsp_valid),
      .rsp_done_kind  (rsp_done_kind),
      .rsp_result_id  (rsp_result_id),
      .rsp_result_tag (rsp_result_tag),
      .rsp_status     (rsp_status),
      .rsp_pending    (rsp_pending),
      .rsp_last       (rsp_last)
   );

   // Every acknowledgment is the only result of its command.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_done_kind != KIND_TICK) |-> rsp_last)
      else $error("acknowledgment without last mark");

   // A refused schedule happens only with the table full.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |-> (rsp_pending == PEND_BITS'(TABLE_DEPTH)))
      else $error("table full reported with free entries");

   // A clear leaves nothing pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_done_kind == KIND_CLEAR) |-> (rsp_pending == '0))
      else $error("clear acknowledged with timers pending");

   // Expiries never report a failure status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_done_kind == KIND_TICK) |-> (rsp_status == STATUS_OK))
      else $error("expiry with error status");

endmodule

/* tb/tb_deadline_timer_queue_top.sv */
// Self-checking testbench for the deadline timer queue: directed table, cancel run and random words.
`timescale 1ns / 1ps

module tb_deadline_timer_queue_top;
   import dtq_pkg::*;

   localparam int DEPTH = DEF_TABLE_DEPTH;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] id;
      logic [15:0] tag;
      logic [1:0]  status;
      logic [4:0]  pending;
      logic        last;
   } outcome_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] delay;
      logic [15:0] tid;
      logic [15:0] tag;
      logic [4:0]  reps;
      logic        typed;
      outcome_type want;
   } row_type;

   localparam outcome_type NO_FIX = '0;
   localparam int NUM_ROWS = 21;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_kind;
   logic [31:0] req_delay;
   logic [15:0] req_timer_id;
   logic [15:0] req_user_tag;
   logic        rsp_valid;
   logic [1:0]  rsp_done_kind;
   logic [15:0] rsp_result_id;
   logic [15:0] rsp_result_tag;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_pending;
   logic        rsp_last;

   logic [63:0] now_ms;
   logic [15:0] last_id;
   logic [63:0] tmr_deadline [0:DEPTH-1];
   logic [15:0] tmr_id [0:DEPTH-1];
   logic [15:0] tmr_tag [0:DEPTH-1];
   int          tmr_count;

   outcome_type outcome_q[$];
   outcome_type fresh_q[$];
   int          idle_pct;
   int          errors;
   int          words_sent;
   int          results_seen;
   int          expiries_seen;

   deadline_timer_queue_top uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_delay(req_delay),
      .req_timer_id(req_timer_id),
      .req_user_tag(req_user_tag),
      .rsp_valid(rsp_valid),
      .rsp_done_kind(rsp_done_kind),
      .rsp_result_id(rsp_result_id),
      .rsp_result_tag(rsp_result_tag),
      .rsp_status(rsp_status),
      .rsp_pending(rsp_pending),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #30000000;
      $display("Timeout at %0t with %0d results outstanding.", $time, outcome_q.size());
      $display("DONE: errors detected");
      $finish;
   end

   function automatic outcome_type timer_result(input logic [1:0] kind, input logic [15:0] id,
                                                input logic [15:0] tag,
                                                input logic [1:0] status, input logic last);
      outcome_type o;
      o.kind    = kind;
      o.id      = id;
      o.tag     = tag;
      o.status  = status;
      o.pending = tmr_count[4:0];
      o.last    = last;
      return o;
   endfunction

   function automatic void remove_timer(input int pos);
      int k;
      for (k = pos; k + 1 < tmr_count; k++) begin
         tmr_deadline[k] = tmr_deadline[k + 1];
         tmr_id[k]       = tmr_id[k + 1];
         tmr_tag[k]      = tmr_tag[k + 1];
      end
      tmr_count--;
   endfunction

   // Applies one accepted word to the timer table and leaves its results in fresh_q.
   function automatic void timer_table_step(input logic [1:0] kind, input logic [31:0] delay,
                                            input logic [15:0] tid, input logic [15:0] tag);
      int          pos;
      int          k;
      int          n;
      bit          found;
      logic [63:0] dl;
      logic [15:0] gone_id;
      logic [15:0] gone_tag;
      fresh_q.delete();
      case (kind)
         KIND_SCHEDULE: begin
            if (tmr_count >= DEPTH) begin
               fresh_q.push_back(timer_result(KIND_SCHEDULE, 16'd0, 16'd0, STATUS_FULL, 1'b1));
            end else begin
               last_id = last_id + 16'd1;
               if (last_id == 16'd0) last_id = 16'd1;
               dl = now_ms + {32'd0, delay};
               pos = 0;
               while (pos < tmr_count && tmr_deadline[pos] <= dl) pos++;
               for (k = tmr_count; k > pos; k--) begin
                  tmr_deadline[k] = tmr_deadline[k - 1];
                  tmr_id[k]       = tmr_id[k - 1];
                  tmr_tag[k]      = tmr_tag[k - 1];
               end
               tmr_deadline[pos] = dl;
               tmr_id[pos]       = last_id;
               tmr_tag[pos]      = tag;
               tmr_count++;
               fresh_q.push_back(timer_result(KIND_SCHEDULE, last_id, 16'd0, STATUS_OK, 1'b1));
            end
         end
         KIND_CANCEL: begin
            if (tid == 16'd0) begin
               fresh_q.push_back(timer_result(KIND_CANCEL, 16'd0, 16'd0, STATUS_OK, 1'b1));
            end else begin
               found = 1'b0;
               for (pos = 0; pos < tmr_count && !found; pos++) begin
                  if (tmr_id[pos] == tid) begin
                     found = 1'b1;
                     remove_timer(pos);
                  end
               end
               if (found)
                  fresh_q.push_back(timer_result(KIND_CANCEL, tid, 16'd0, STATUS_OK, 1'b1));
               else
                  fresh_q.push_back(timer_result(KIND_CANCEL, 16'd0, 16'd0,
                                                 STATUS_NOT_FOUND, 1'b1));
            end
         end
         KIND_TICK: begin
            now_ms = now_ms + 64'd1;
            n = 0;
            while (n < MAX_RESULTS && tmr_count > 0 && tmr_deadline[0] <= now_ms) begin
               gone_id  = tmr_id[0];
               gone_tag = tmr_tag[0];
               remove_timer(0);
               fresh_q.push_back(timer_result(KIND_TICK, gone_id, gone_tag, STATUS_OK, 1'b0));
               n++;
            end
            if (n > 0) fresh_q[n - 1].last = 1'b1;
         end
         default: begin
            tmr_count = 0;
            fresh_q.push_back(timer_result(KIND_CLEAR, 16'd0, 16'd0, STATUS_OK, 1'b1));
         end
      endcase
   endfunction

   task automatic send_word(input logic [1:0] kind, input logic [31:0] delay,
                            input logic [15:0] tid, input logic [15:0] tag,
                            input logic typed, input outcome_type want);
      @(negedge clock);
      while ($urandom_range(99, 0) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_kind     = kind;
      req_delay    = delay;
      req_timer_id = tid;
      req_user_tag = tag;
      start        = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      timer_table_step(kind, delay, tid, tag);
      if (typed)
         outcome_q.push_back(want);
      else
         foreach (fresh_q[i]) outcome_q.push_back(fresh_q[i]);
      words_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      start = 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
   endtask

   task automatic random_phase(input int pct_idle, input int pct_sched, input int words);
      int          r;
      logic [1:0]  kind;
      logic [31:0] delay;
      logic [15:0] tid;
      idle_pct = pct_idle;
      repeat (words) begin
         r = $urandom_range(99, 0);
         if (r < pct_sched)
            kind = KIND_SCHEDULE;
         else if (r < pct_sched + (100 - pct_sched) * 2 / 5)
            kind = KIND_CANCEL;
         else if (r < 96)
            kind = KIND_TICK;
         else
            kind = KIND_CLEAR;
         r = $urandom_range(99, 0);
         if (r < 70)
            delay = $urandom_range(12, 0);
         else if (r < 90)
            delay = $urandom_range(200, 0);
         else
            delay = $urandom;
         r = $urandom_range(99, 0);
         if (r < 60 && tmr_count > 0)
            tid = tmr_id[$urandom_range(tmr_count - 1, 0)];
         else if (r < 70)
            tid = 16'd0;
         else
            tid = 16'($urandom);
         send_word(kind, delay, tid, 16'($urandom), 1'b0, NO_FIX);
      end
   endtask

   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (!reset && rsp_valid) begin
         got = '{rsp_done_kind, rsp_result_id, rsp_result_tag, rsp_status, rsp_pending,
                 rsp_last};
         results_seen++;
         if (rsp_done_kind == KIND_TICK) expiries_seen++;
         if (outcome_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result kind=%0d id=%h tag=%h status=%0d pending=%0d last=%0d",
                     $time, got.kind, got.id, got.tag, got.status, got.pending, got.last);
         end else begin
            want = outcome_q.pop_front();
            if (got != want) begin
               errors++;
               $display("%0t: mismatch expected kind=%0d id=%h tag=%h status=%0d pending=%0d last=%0d",
                        $time, want.kind, want.id, want.tag, want.status, want.pending, want.last);
               $display("%0t:          actual   kind=%0d id=%h tag=%h status=%0d pending=%0d last=%0d",
                        $time, got.kind, got.id, got.tag, got.status, got.pending, got.last);
            end
         end
      end
   end

   initial begin
      row_type     plan [0:NUM_ROWS-1];
      logic [15:0] old_id;
      plan[0]  = '{KIND_CANCEL, 32'd0, 16'd0, 16'd0, 5'd1, 1'b1,
                   '{KIND_CANCEL, 16'd0, 16'd0, STATUS_OK, 5'd0, 1'b1}};
      plan[1]  = '{KIND_CANCEL, 32'd0, 16'hFFFF, 16'd0, 5'd1, 1'b1,
                   '{KIND_CANCEL, 16'd0, 16'd0, STATUS_NOT_FOUND, 5'd0, 1'b1}};
      plan[2]  = '{KIND_TICK, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 5'd1, 1'b0, NO_FIX};
      plan[3]  = '{KIND_SCHEDULE, 32'd0, 16'd0, 16'hFFFF, 5'd1, 1'b1,
                   '{KIND_SCHEDULE, 16'd1, 16'd0, STATUS_OK, 5'd1, 1'b1}};
      plan[4]  = '{KIND_TICK, 32'd0, 16'd0, 16'd0, 5'd1, 1'b0, NO_FIX};
      plan[5]  = '{KIND_SCHEDULE, 32'hFFFFFFFF, 16'hFFFF, 16'h0000, 5'd1, 1'b1,
                   '{KIND_SCHEDULE, 16'd2, 16'd0, STATUS_OK, 5'd1, 1'b1}};
      plan[6]  = '{KIND_SCHEDULE, 32'd5, 16'd0, 16'hAAAA, 5'd1, 1'b0, NO_FIX};
      plan[7]  = '{KIND_SCHEDULE, 32'd5, 16'd0, 16'h5555, 5'd1, 1'b0, NO_FIX};
      plan[8]  = '{KIND_SCHEDULE, 32'd3, 16'd0, 16'h0001, 5'd1, 1'b0, NO_FIX};
      plan[9]  = '{KIND_CANCEL, 32'd0, 16'd4, 16'd0, 5'd1, 1'b0, NO_FIX};
      plan[10] = '{KIND_CANCEL, 32'd0, 16'd4, 16'd0, 5'd1, 1'b1,
                   '{KIND_CANCEL, 16'd0, 16'd0, STATUS_NOT_FOUND, 5'd3, 1'b1}};
      plan[11] = '{KIND_TICK, 32'd0, 16'd0, 16'd0, 5'd6, 1'b0, NO_FIX};
      plan[12] = '{KIND_CLEAR, 32'd0, 16'd0, 16'd0, 5'd1, 1'b1,
                   '{KIND_CLEAR, 16'd0, 16'd0, STATUS_OK, 5'd0, 1'b1}};
      plan[13] = '{KIND_SCHEDULE, 32'd2, 16'd0, 16'h00F0, 5'd16, 1'b0, NO_FIX};
      plan[14] = '{KIND_SCHEDULE, 32'd7, 16'd0, 16'h1234, 5'd1, 1'b1,
                   '{KIND_SCHEDULE, 16'd0, 16'd0, STATUS_FULL, 5'd16, 1'b1}};
      plan[15] = '{KIND_CANCEL, 32'd0, 16'd0, 16'd0, 5'd1, 1'b1,
                   '{KIND_CANCEL, 16'd0, 16'd0, STATUS_OK, 5'd16, 1'b1}};
      plan[16] = '{KIND_TICK, 32'd0, 16'd0, 16'd0, 5'd2, 1'b0, NO_FIX};
      plan[17] = '{KIND_SCHEDULE, 32'd1, 16'd0, 16'h7FFF, 5'd1, 1'b0, NO_FIX};
      plan[18] = '{KIND_SCHEDULE, 32'd1, 16'd0, 16'h8000, 5'd1, 1'b0, NO_FIX};
      plan[19] = '{KIND_CLEAR, 32'd0, 16'd0, 16'd0, 5'd1, 1'b1,
                   '{KIND_CLEAR, 16'd0, 16'd0, STATUS_OK, 5'd0, 1'b1}};
      plan[20] = '{KIND_TICK, 32'd0, 16'd0, 16'd0, 5'd1, 1'b0, NO_FIX};

      reset         = 1'b1;
      start         = 1'b0;
      req_kind      = KIND_SCHEDULE;
      req_delay     = 32'd0;
      req_timer_id  = 16'd0;
      req_user_tag  = 16'd0;
      now_ms        = 64'd0;
      last_id       = 16'd0;
      tmr_count     = 0;
      idle_pct      = 0;
      errors        = 0;
      words_sent    = 0;
      results_seen  = 0;
      expiries_seen = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < NUM_ROWS; i++)
         for (int r = 0; r < plan[i].reps; r++)
            send_word(plan[i].kind, plan[i].delay, plan[i].tid, plan[i].tag,
                      plan[i].typed, plan[i].want);
      drain_results();

      // Cancel one long-lived timer repeatedly, then let one of two short timers expire while the
      // remaining long-lived ones stay pending.
      send_word(KIND_CLEAR, 32'd0, 16'd0, 16'd0, 1'b0, NO_FIX);
      old_id = last_id + 16'd1;
      repeat (3) send_word(KIND_SCHEDULE, 32'h80000000, 16'd0, 16'($urandom), 1'b0, NO_FIX);
      send_word(KIND_SCHEDULE, 32'd9, 16'd0, 16'hBEEF, 1'b0, NO_FIX);
      repeat (3) send_word(KIND_CANCEL, 32'd0, old_id, 16'd0, 1'b0, NO_FIX);
      send_word(KIND_SCHEDULE, 32'd1, 16'd0, 16'hCAFE, 1'b0, NO_FIX);
      repeat (2) send_word(KIND_TICK, 32'd0, 16'd0, 16'd0, 1'b0, NO_FIX);
      send_word(KIND_CANCEL, 32'd0, old_id + 16'd1, 16'd0, 1'b0, NO_FIX);
      send_word(KIND_CLEAR, 32'd0, 16'd0, 16'd0, 1'b0, NO_FIX);
      drain_results();

      random_phase(0, 40, 39);
      random_phase(85, 55, 39);
      drain_results();
      random_phase(20, 70, 39);
      random_phase(0, 40, 39);
      drain_results();
      repeat (40) @(posedge clock);

      $display("Sent %0d words (directed table, cancel run, random) and checked %0d results,",
               words_sent, results_seen);
      $display("of which %0d were timer expiries; %0d mismatches.", expiries_seen, errors);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* filelist.f */
sv/dtq_pkg.sv
sv/dtq_front.sv
sv/dtq_back.sv
sv/deadline_timer_queue_top.sv
tb/tb_deadline_timer_queue_top.sv
